// ----- src/i2c_ras_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_ras_pkg
// Types and codes shared by the I2C register access sequencer.
// ----------------------------------------------------------------------------
package i2c_ras_pkg;

   // event codes on the request channel
   localparam logic [1:0] ACT_START_WRITE = 2'd0;
   localparam logic [1:0] ACT_START_READ  = 2'd1;
   localparam logic [1:0] ACT_TX_READY    = 2'd2;
   localparam logic [1:0] ACT_RX_BYTE     = 2'd3;

   // bus commands on the response channel
   localparam logic [2:0] CMD_NONE          = 3'd0;
   localparam logic [2:0] CMD_START_TX      = 3'd1;
   localparam logic [2:0] CMD_SEND_BYTE     = 3'd2;
   localparam logic [2:0] CMD_RSTART_RX     = 3'd3;
   localparam logic [2:0] CMD_RSTART_RX_STP = 3'd4;
   localparam logic [2:0] CMD_STOP          = 3'd5;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_REGADDR = 3'd1,
      PH_SWITCH  = 3'd2,
      PH_TXDATA  = 3'd3,
      PH_RXDATA  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [1:0] action;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic [7:0] byte_count;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] bus_command;
      logic [7:0] send_byte;
      logic [6:0] target_address;
      logic       store_valid;
      logic [7:0] store_byte;
      logic       done_res;
   } rsp_type;

endpackage

// ----- src/i2c_ras_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_ras_core
// Transaction state and the next-state / result logic. State advances on
// every fired event; the result is combinational from the held event.
// ----------------------------------------------------------------------------
module i2c_ras_core import i2c_ras_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   phase_type  phase_ff, phase_in;
   logic [7:0] reg_offs_ff, reg_offs_in;
   logic [7:0] wr_left_ff, wr_left_in;
   logic [7:0] rd_left_ff, rd_left_in;
   logic [6:0] tgt_addr_ff, tgt_addr_in;
   logic [7:0] rd_left_dec;

   assign rd_left_dec = (rd_left_ff != 8'd0) ? rd_left_ff - 8'd1 : 8'd0;

   always_comb begin
      phase_in    = phase_ff;
      reg_offs_in = reg_offs_ff;
      wr_left_in  = wr_left_ff;
      rd_left_in  = rd_left_ff;
      tgt_addr_in = tgt_addr_ff;
      result      = '0;
      case (item.action)
         ACT_START_WRITE, ACT_START_READ: begin
            // a start while busy simply restarts
            phase_in    = PH_REGADDR;
            tgt_addr_in = item.device_address;
            reg_offs_in = item.register_address;
            wr_left_in  = (item.action == ACT_START_WRITE) ? item.byte_count : 8'd0;
            rd_left_in  = (item.action == ACT_START_READ) ? item.byte_count : 8'd0;
            result.bus_command    = CMD_START_TX;
            result.target_address = item.device_address;
         end
         ACT_TX_READY: begin
            case (phase_ff)
               PH_REGADDR: begin
                  result.bus_command = CMD_SEND_BYTE;
                  result.send_byte   = reg_offs_ff;
                  phase_in = (rd_left_ff != 8'd0) ? PH_SWITCH : PH_TXDATA;
               end
               PH_SWITCH: begin
                  result.bus_command = (rd_left_ff == 8'd1) ? CMD_RSTART_RX_STP
                                                            : CMD_RSTART_RX;
                  phase_in = PH_RXDATA;
               end
               PH_TXDATA: begin
                  if (wr_left_ff != 8'd0) begin
                     result.bus_command = CMD_SEND_BYTE;
                     result.send_byte   = item.data_byte;
                     wr_left_in         = wr_left_ff - 8'd1;
                  end else begin
                     result.bus_command = CMD_STOP;
                     result.done_res    = 1'b1;
                     phase_in           = PH_IDLE;
                  end
               end
               default: ;
            endcase
         end
         default: begin
            if (phase_ff == PH_RXDATA) begin
               if (rd_left_ff != 8'd0) begin
                  result.store_valid = 1'b1;
                  result.store_byte  = item.data_byte;
               end
               rd_left_in = rd_left_dec;
               // stop goes out as the last byte is being received
               if (rd_left_dec == 8'd1) begin
                  result.bus_command = CMD_STOP;
               end else if (rd_left_dec == 8'd0) begin
                  result.done_res = 1'b1;
                  phase_in        = PH_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         reg_offs_ff <= 8'd0;
         wr_left_ff  <= 8'd0;
         rd_left_ff  <= 8'd0;
         tgt_addr_ff <= 7'd0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         reg_offs_ff <= reg_offs_in;
         wr_left_ff  <= wr_left_in;
         rd_left_ff  <= rd_left_in;
         tgt_addr_ff <= tgt_addr_in;
      end
   end

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      fire && result.done_res |=> phase_ff == PH_IDLE)
      else $error("done reported but sequencer not idle");

   a_store_on_rx: assert property (@(posedge clock) disable iff (reset)
      result.store_valid |-> item.action == ACT_RX_BYTE && phase_ff == PH_RXDATA)
      else $error("store outside receive phase");

   a_start_regaddr: assert property (@(posedge clock) disable iff (reset)
      fire && (item.action == ACT_START_WRITE || item.action == ACT_START_READ)
      |=> phase_ff == PH_REGADDR && tgt_addr_ff == $past(item.device_address))
      else $error("start did not latch transaction");

   a_rx_count_down: assert property (@(posedge clock) disable iff (reset)
      fire && result.store_valid |=> rd_left_ff == $past(rd_left_ff) - 8'd1)
      else $error("read count not decremented");

endmodule

// ----- src/i2c_register_access_sequencer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer_top
// I2C master register read/write sequencer: turns start commands and bus
// events into bus commands and received-byte stores.
//
//   port group  dir  payload   transfer when
//   req_*       in   req_type  req_valid && !req_stall
//   rsp_*       out  rsp_type  rsp_valid && !rsp_stall
//
// One event per cycle sustained while the response is not stalled; a
// request passes the input register, then the response register. State
// updates as an event moves into the response register. Synchronous
// reset clears state and valids. A stalled response holds; the input
// register keeps taking events until it is full behind the stalled response.
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer_top import i2c_ras_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    req_valid_ff;
   req_type req_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type result;
   logic    rsp_free;
   logic    fire;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && rsp_free;
   assign req_stall = req_valid_ff && !rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_data_ff <= req_data;
      end
   end

   i2c_ras_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (req_data_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
